// ----- hdl/dual_pivot_quicksort_engine_defines.svh -----
// Assertion macros for the dual-pivot quicksort engine checker
`ifndef DUAL_PIVOT_QUICKSORT_ENGINE_DEFINES_SVH
`define DUAL_PIVOT_QUICKSORT_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DPQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpq check failed (same cycle)");

// next-cycle implication
`define DPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpq check failed (next cycle)");

`endif

// ----- hdl/dpq_pkg.sv -----
// Shared types, constants and the key order function of the quicksort engine
`timescale 1ns / 1ps
package dpq_pkg;
   localparam int MAX_KEYS  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W     = $clog2(MAX_KEYS);
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);
   localparam int POS_W     = IDX_W + 2;
   localparam int STK_W     = 2 * IDX_W;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic signed [POS_W-1:0]     pos_type;
   typedef logic [IDX_W-1:0]            idx_type;
   typedef logic [CNT_W-1:0]            cnt_type;
   typedef logic [STK_W-1:0]            stk_type;

   // true when a must stand ahead of b in the output
   function automatic logic key_before(input logic desc, input key_type a, input key_type b);
      return desc ? (a > b) : (a < b);
   endfunction
endpackage

// ----- hdl/dpq_ram.sv -----
// Generic single-port-write, registered-read synchronous RAM
`timescale 1ns / 1ps
module dpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/dpq_sorter.sv -----
// Load, dual-pivot partition and emit sequencer around the key and range memories
`timescale 1ns / 1ps
module dpq_sorter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dpq_pkg::key_type req_key_value,
   input  logic             req_last_key,
   output logic             rsp_strobe,
   output dpq_pkg::key_type rsp_sorted_value,
   output logic             rsp_last_sorted,
   input  logic             csr_we,
   input  logic             csr_sort_descending,
   output logic             key_we,
   output dpq_pkg::idx_type key_waddr,
   output dpq_pkg::key_type key_wdata,
   output dpq_pkg::idx_type key_raddr,
   input  dpq_pkg::key_type key_rdata,
   output logic             stk_we,
   output dpq_pkg::idx_type stk_waddr,
   output dpq_pkg::stk_type stk_wdata,
   output dpq_pkg::idx_type stk_raddr,
   input  dpq_pkg::stk_type stk_rdata
);
   import dpq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_POP, S_POPW, S_RLO, S_RHI, S_PIV2, S_LOOP, S_K,
      S_JCHK, S_JW, S_KJ2, S_KI1, S_KI2, S_FIN, S_F1, S_F2, S_F3, S_F4,
      S_P1, S_P2, S_P3, S_E0, S_E1
   } state_type;

   state_type state_ff;
   cnt_type   count_ff, sp_ff, m_ff;
   pos_type   lo_ff, hi_ff, i_ff, j_ff, k_ff;
   key_type   lp_ff, hp_ff, vk_ff, vj_ff;
   logic      desc_ff;
   logic      strobe_ff, last_ff;
   key_type   out_ff;

   pos_type push_lo, push_hi;
   logic    rhi_swap;

   assign rhi_swap = key_before(desc_ff, key_rdata, lp_ff);

   always_comb begin
      key_we    = 1'b0;
      key_waddr = '0;
      key_wdata = '0;
      key_raddr = '0;
      stk_raddr = idx_type'(sp_ff - cnt_type'(1));
      push_lo   = '0;
      push_hi   = '0;
      unique case (state_ff)
         S_IDLE: begin
            key_we    = start;
            key_waddr = count_ff[IDX_W-1:0];
            key_wdata = req_key_value;
         end
         S_INIT: begin
            push_lo = '0;
            push_hi = pos_type'({1'b0, count_ff}) - pos_type'(1);
         end
         S_POPW: key_raddr = stk_rdata[STK_W-1:IDX_W];
         S_RLO:  key_raddr = hi_ff[IDX_W-1:0];
         S_RHI: begin
            key_we    = 1'b1;
            key_waddr = lo_ff[IDX_W-1:0];
            key_wdata = rhi_swap ? key_rdata : lp_ff;
         end
         S_PIV2: begin
            key_we    = 1'b1;
            key_waddr = hi_ff[IDX_W-1:0];
            key_wdata = hp_ff;
         end
         S_LOOP: key_raddr = k_ff[IDX_W-1:0];
         S_K:    key_raddr = i_ff[IDX_W-1:0];
         S_JCHK: key_raddr = j_ff[IDX_W-1:0];
         S_JW: begin
            key_waddr = k_ff[IDX_W-1:0];
            key_wdata = key_rdata;
            key_we    = !(key_before(desc_ff, hp_ff, key_rdata) && (k_ff < j_ff));
         end
         S_KJ2: begin
            key_we    = 1'b1;
            key_waddr = j_ff[IDX_W-1:0];
            key_wdata = vk_ff;
            key_raddr = i_ff[IDX_W-1:0];
         end
         S_KI1: begin
            key_we    = 1'b1;
            key_waddr = k_ff[IDX_W-1:0];
            key_wdata = key_rdata;
         end
         S_KI2: begin
            key_we    = 1'b1;
            key_waddr = i_ff[IDX_W-1:0];
            key_wdata = vk_ff;
         end
         S_FIN: key_raddr = idx_type'(i_ff - pos_type'(1));
         S_F1: begin
            key_we    = 1'b1;
            key_waddr = lo_ff[IDX_W-1:0];
            key_wdata = key_rdata;
         end
         S_F2: begin
            key_we    = 1'b1;
            key_waddr = i_ff[IDX_W-1:0];
            key_wdata = lp_ff;
            key_raddr = j_ff[IDX_W-1:0];
         end
         S_F3: begin
            key_we    = 1'b1;
            key_waddr = hi_ff[IDX_W-1:0];
            key_wdata = key_rdata;
         end
         S_F4: begin
            key_we    = 1'b1;
            key_waddr = j_ff[IDX_W-1:0];
            key_wdata = hp_ff;
         end
         S_P1: begin
            push_lo = lo_ff;
            push_hi = i_ff - pos_type'(1);
         end
         S_P2: begin
            push_lo = i_ff + pos_type'(1);
            push_hi = j_ff - pos_type'(1);
         end
         S_P3: begin
            push_lo = j_ff + pos_type'(1);
            push_hi = hi_ff;
         end
         S_E0:   key_raddr = '0;
         S_E1:   key_raddr = m_ff[IDX_W-1:0];
         default: ;
      endcase
   end

   // push only ranges of two keys or more
   assign stk_we = (state_ff == S_INIT || state_ff == S_P1 || state_ff == S_P2 ||
                    state_ff == S_P3) && (push_lo < push_hi) &&
                   (sp_ff < cnt_type'(MAX_KEYS));
   assign stk_waddr = sp_ff[IDX_W-1:0];
   assign stk_wdata = {push_lo[IDX_W-1:0], push_hi[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sp_ff     <= '0;
         m_ff      <= '0;
         desc_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         if (csr_we) begin
            desc_ff <= csr_sort_descending;
         end
         if (stk_we) begin
            sp_ff <= sp_ff + cnt_type'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  count_ff <= count_ff + cnt_type'(1);
                  if (req_last_key || (count_ff + cnt_type'(1) == cnt_type'(MAX_KEYS))) begin
                     state_ff <= S_INIT;
                     sp_ff    <= '0;
                  end
               end
            end
            S_INIT: state_ff <= S_POP;
            S_POP: begin
               if (sp_ff == '0) begin
                  state_ff <= S_E0;
               end else begin
                  sp_ff    <= sp_ff - cnt_type'(1);
                  state_ff <= S_POPW;
               end
            end
            S_POPW: begin
               lo_ff    <= pos_type'({2'b00, stk_rdata[STK_W-1:IDX_W]});
               hi_ff    <= pos_type'({2'b00, stk_rdata[IDX_W-1:0]});
               state_ff <= S_RLO;
            end
            S_RLO: begin
               lp_ff    <= key_rdata;
               state_ff <= S_RHI;
            end
            S_RHI: begin
               lp_ff    <= rhi_swap ? key_rdata : lp_ff;
               hp_ff    <= rhi_swap ? lp_ff : key_rdata;
               i_ff     <= lo_ff + pos_type'(1);
               k_ff     <= lo_ff + pos_type'(1);
               j_ff     <= hi_ff - pos_type'(1);
               state_ff <= S_PIV2;
            end
            S_PIV2: state_ff <= S_LOOP;
            S_LOOP: state_ff <= (k_ff <= j_ff) ? S_K : S_FIN;
            S_K: begin
               vk_ff <= key_rdata;
               if (key_before(desc_ff, key_rdata, lp_ff)) begin
                  state_ff <= S_KI1;
               end else if (!key_before(desc_ff, key_rdata, hp_ff)) begin
                  state_ff <= S_JCHK;
               end else begin
                  k_ff     <= k_ff + pos_type'(1);
                  state_ff <= S_LOOP;
               end
            end
            S_JCHK: state_ff <= S_JW;
            S_JW: begin
               vj_ff <= key_rdata;
               if (key_before(desc_ff, hp_ff, key_rdata) && (k_ff < j_ff)) begin
                  j_ff     <= j_ff - pos_type'(1);
                  state_ff <= S_JCHK;
               end else begin
                  state_ff <= S_KJ2;
               end
            end
            S_KJ2: begin
               j_ff <= j_ff - pos_type'(1);
               if (key_before(desc_ff, vj_ff, lp_ff)) begin
                  vk_ff    <= vj_ff;
                  state_ff <= S_KI1;
               end else begin
                  k_ff     <= k_ff + pos_type'(1);
                  state_ff <= S_LOOP;
               end
            end
            S_KI1: state_ff <= S_KI2;
            S_KI2: begin
               i_ff     <= i_ff + pos_type'(1);
               k_ff     <= k_ff + pos_type'(1);
               state_ff <= S_LOOP;
            end
            S_FIN: begin
               i_ff     <= i_ff - pos_type'(1);
               j_ff     <= j_ff + pos_type'(1);
               state_ff <= S_F1;
            end
            S_F1: state_ff <= S_F2;
            S_F2: state_ff <= S_F3;
            S_F3: state_ff <= S_F4;
            S_F4: state_ff <= S_P1;
            S_P1: state_ff <= S_P2;
            S_P2: state_ff <= S_P3;
            S_P3: state_ff <= S_POP;
            S_E0: begin
               m_ff     <= cnt_type'(1);
               state_ff <= S_E1;
            end
            S_E1: begin
               strobe_ff <= 1'b1;
               out_ff    <= key_rdata;
               last_ff   <= (m_ff == count_ff);
               m_ff      <= m_ff + cnt_type'(1);
               if (m_ff == count_ff) begin
                  count_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = out_ff;
   assign rsp_last_sorted  = last_ff;
endmodule

// ----- hdl/dual_pivot_quicksort_engine.sv -----
// Top level of the dual-pivot quicksort engine
// Keys load one per cycle while busy is low; the key that carries req_last_key,
// or the key that fills the 64-entry store, starts an in-place dual-pivot
// quicksort, with pending ranges held on a range stack in a second memory.
// The sort runs on one key memory with one read and one write per cycle.
// Each partitioned range is popped from the stack, its two pivots are read,
// ordered and placed, each key between them is compared with both pivots and
// swapped as needed, and the pivots are moved to their final places before the
// sub-ranges are pushed; ranges of one key are never pushed. The sorted keys
// then leave one per cycle on rsp_strobe, the final one with rsp_last_sorted;
// the receiver cannot stall them. busy falls with the final strobe.
// csr_sort_descending must be written only while busy is low (the block does
// not enforce this) and applies from the next set.
`timescale 1ns / 1ps
module dual_pivot_quicksort_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dpq_pkg::key_type req_key_value,
   input  logic             req_last_key,
   output logic             rsp_strobe,
   output dpq_pkg::key_type rsp_sorted_value,
   output logic             rsp_last_sorted,
   input  logic             csr_we,
   input  logic             csr_sort_descending
);
   import dpq_pkg::*;

   logic    key_we, stk_we;
   idx_type key_waddr, key_raddr, stk_waddr, stk_raddr;
   key_type key_wdata, key_rdata;
   stk_type stk_wdata, stk_rdata;

   dpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_KEYS)) u_key_store (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   dpq_ram #(.WIDTH(STK_W), .DEPTH(MAX_KEYS)) u_range_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   dpq_sorter u_sorter (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_key_value       (req_key_value),
      .req_last_key        (req_last_key),
      .rsp_strobe          (rsp_strobe),
      .rsp_sorted_value    (rsp_sorted_value),
      .rsp_last_sorted     (rsp_last_sorted),
      .csr_we              (csr_we),
      .csr_sort_descending (csr_sort_descending),
      .key_we              (key_we),
      .key_waddr           (key_waddr),
      .key_wdata           (key_wdata),
      .key_raddr           (key_raddr),
      .key_rdata           (key_rdata),
      .stk_we              (stk_we),
      .stk_waddr           (stk_waddr),
      .stk_wdata           (stk_wdata),
      .stk_raddr           (stk_raddr),
      .stk_rdata           (stk_rdata)
   );
endmodule

// ----- hdl/dpq_checker.sv -----
// Port-level checker for the quicksort engine, bound to the top level
`timescale 1ns / 1ps
`include "dual_pivot_quicksort_engine_defines.svh"
module dpq_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_key,
   input logic rsp_strobe,
   input logic rsp_last_sorted
);
   `DPQ_ASSERT_NOW(last_has_strobe, rsp_last_sorted, rsp_strobe)
   `DPQ_ASSERT_NOW(strobe_after_busy, rsp_strobe, $past(busy))
   `DPQ_ASSERT_NOW(idle_after_last, rsp_strobe && rsp_last_sorted, !busy)
   `DPQ_ASSERT_NEXT(last_starts_sort, start && !busy && req_last_key, busy)
endmodule

bind dual_pivot_quicksort_engine dpq_checker u_dpq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_last_key    (req_last_key),
   .rsp_strobe      (rsp_strobe),
   .rsp_last_sorted (rsp_last_sorted)
);
